// File: src/homogeneous_vertex_transform_unit_macros.svh
// Assertion macros for the homogeneous vertex transform unit.
// Used by the top level only; no other dependencies.
`ifndef HOMOGENEOUS_VERTEX_TRANSFORM_UNIT_MACROS_SVH
`define HOMOGENEOUS_VERTEX_TRANSFORM_UNIT_MACROS_SVH
`ifndef SYNTH
// same-cycle implication, disabled during reset
`define HVT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication check failed");
// next-cycle implication, disabled during reset
`define HVT_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");
// next-cycle implication that also holds across reset
`define HVT_ASSERT_NXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("%m: reset check failed");
`else
`define HVT_ASSERT_IMP(label, clk, rst, ante, cons)
`define HVT_ASSERT_NXT(label, clk, rst, ante, cons)
`define HVT_ASSERT_NXT_ALWAYS(label, clk, ante, cons)
`endif
`endif

// File: src/hvt_pkg.sv
// Shared types, constants and helpers of the homogeneous vertex transform unit.
// No dependencies.
`default_nettype none

package hvt_pkg;

   localparam int VEC_N               = 4;   // vector length and matrix order
   localparam int MAT_W               = 32;  // width of one matrix entry
   localparam int DATA_W              = 32;  // width of a coordinate field
   localparam int REG_W               = 64;  // width of a matrix register
   localparam int NUM_REGS            = 8;
   localparam int CSR_IDX_W           = 4;
   localparam int FRAC_BITS_DEFAULT   = 16;
   localparam int COORD_WIDTH_DEFAULT = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_COL1_ROWS12 = 4'd0,
      REG_COL1_ROWS34 = 4'd1,
      REG_COL2_ROWS12 = 4'd2,
      REG_COL2_ROWS34 = 4'd3,
      REG_COL3_ROWS12 = 4'd4,
      REG_COL3_ROWS34 = 4'd5,
      REG_COL4_ROWS12 = 4'd6,
      REG_COL4_ROWS34 = 4'd7
   } csr_reg_type;

   // identity matrix, Q16.16
   localparam logic [REG_W-1:0] REG_RESET [NUM_REGS] = '{
      64'h0000_0000_0001_0000, 64'h0000_0000_0000_0000,
      64'h0001_0000_0000_0000, 64'h0000_0000_0000_0000,
      64'h0000_0000_0000_0000, 64'h0000_0000_0001_0000,
      64'h0000_0000_0000_0000, 64'h0001_0000_0000_0000
   };

   typedef struct packed {
      logic signed [DATA_W-1:0] x_in;
      logic signed [DATA_W-1:0] y_in;
      logic signed [DATA_W-1:0] z_in;
      logic signed [DATA_W-1:0] w_in;
      logic                     w_given;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] x_out;
      logic signed [DATA_W-1:0] y_out;
      logic signed [DATA_W-1:0] z_out;
      logic signed [DATA_W-1:0] w_out;
      logic                     saturated;
   } rsp_type;

   // operand width: holds a coordinate and also the constant 1.0
   function automatic int opnd_width(int coord_w, int frac_b);
      return (coord_w > frac_b + 1) ? coord_w : frac_b + 2;
   endfunction

endpackage

`default_nettype wire

// File: src/hvt_mul_array.sv
// Stage 1: sixteen matrix-entry by coordinate products, registered.
// Depends on hvt_pkg.
`default_nettype none

module hvt_mul_array
   import hvt_pkg::*;
#(
   parameter int FRAC_BITS   = FRAC_BITS_DEFAULT,
   parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT,
   localparam int OPW        = opnd_width(COORD_WIDTH, FRAC_BITS),
   localparam int PW         = MAT_W + OPW
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  req_type              req_i,
   input  logic [REG_W-1:0]     mat_i [NUM_REGS],
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic signed [PW-1:0] prod_o [VEC_N][VEC_N]
);

   localparam logic signed [OPW-1:0] ONE_Q = OPW'(1 << FRAC_BITS);

   logic signed [OPW-1:0]   vec [VEC_N];
   logic signed [MAT_W-1:0] ent [VEC_N][VEC_N];
   logic signed [PW-1:0]    prod_in [VEC_N][VEC_N];
   logic signed [PW-1:0]    prod_ff [VEC_N][VEC_N];
   logic                    vld_in, vld_ff;

   // sign-extend the used coordinate bits; w falls back to 1.0
   always_comb begin
      vec[0] = OPW'(signed'(req_i.x_in[COORD_WIDTH-1:0]));
      vec[1] = OPW'(signed'(req_i.y_in[COORD_WIDTH-1:0]));
      vec[2] = OPW'(signed'(req_i.z_in[COORD_WIDTH-1:0]));
      vec[3] = req_i.w_given ? OPW'(signed'(req_i.w_in[COORD_WIDTH-1:0])) : ONE_Q;
      for (int r = 0; r < VEC_N; r++) begin
         for (int c = 0; c < VEC_N; c++) begin
            ent[r][c]     = signed'(mat_i[2*c + (r >> 1)][(r & 1)*MAT_W +: MAT_W]);
            prod_in[r][c] = ent[r][c] * vec[c];
         end
      end
   end

   assign in_ready = !vld_ff || out_ready;
   assign vld_in   = in_ready ? in_valid : vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         prod_ff <= prod_in;
      end
   end

   assign out_valid = vld_ff;
   assign prod_o    = prod_ff;

endmodule

`default_nettype wire

// File: src/hvt_sum_tree.sv
// Stages 2 and 3: pairwise product sums, then row sum plus rounding bias.
// Depends on hvt_pkg.
`default_nettype none

module hvt_sum_tree
   import hvt_pkg::*;
#(
   parameter int FRAC_BITS   = FRAC_BITS_DEFAULT,
   parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT,
   localparam int OPW        = opnd_width(COORD_WIDTH, FRAC_BITS),
   localparam int PW         = MAT_W + OPW,
   localparam int SW         = PW + 3
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic signed [PW-1:0] prod_i [VEC_N][VEC_N],
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic signed [SW-1:0] sum_o [VEC_N]
);

   localparam logic signed [SW-1:0] RND = SW'(64'(1) << (FRAC_BITS - 1));

   logic signed [PW:0]   pair_in [VEC_N][2];
   logic signed [PW:0]   pair_ff [VEC_N][2];
   logic signed [SW-1:0] sum_in  [VEC_N];
   logic signed [SW-1:0] sum_ff  [VEC_N];
   logic                 v2_in, v2_ff, v3_in, v3_ff;
   logic                 rdy2, rdy3;

   always_comb begin
      for (int r = 0; r < VEC_N; r++) begin
         pair_in[r][0] = (PW+1)'(prod_i[r][0]) + (PW+1)'(prod_i[r][1]);
         pair_in[r][1] = (PW+1)'(prod_i[r][2]) + (PW+1)'(prod_i[r][3]);
         sum_in[r]     = SW'(pair_ff[r][0]) + SW'(pair_ff[r][1]) + RND;
      end
   end

   assign rdy3     = !v3_ff || out_ready;
   assign rdy2     = !v2_ff || rdy3;
   assign in_ready = rdy2;
   assign v2_in    = rdy2 ? in_valid : v2_ff;
   assign v3_in    = rdy3 ? v2_ff : v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && rdy2) begin
         pair_ff <= pair_in;
      end
      if (v2_ff && rdy3) begin
         sum_ff <= sum_in;
      end
   end

   assign out_valid = v3_ff;
   assign sum_o     = sum_ff;

endmodule

`default_nettype wire

// File: src/hvt_round_sat.sv
// Stage 4: shift out the fraction, saturate and hold the result beat.
// Depends on hvt_pkg.
`default_nettype none

module hvt_round_sat
   import hvt_pkg::*;
#(
   parameter int FRAC_BITS   = FRAC_BITS_DEFAULT,
   parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT,
   localparam int OPW        = opnd_width(COORD_WIDTH, FRAC_BITS),
   localparam int SW         = MAT_W + OPW + 3
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic signed [SW-1:0] sum_i [VEC_N],
   output logic                 out_valid,
   input  logic                 out_ready,
   output rsp_type              rsp_o
);

   logic signed [SW-1:0]          shifted [VEC_N];
   logic [SW-COORD_WIDTH:0]       hi      [VEC_N];
   logic signed [COORD_WIDTH-1:0] clip    [VEC_N];
   logic [VEC_N-1:0]              ovf;
   rsp_type                       rsp_in, rsp_ff;
   logic                          vld_in, vld_ff;

   always_comb begin
      for (int r = 0; r < VEC_N; r++) begin
         shifted[r] = sum_i[r] >>> FRAC_BITS;
         hi[r]      = shifted[r][SW-1:COORD_WIDTH-1];
         ovf[r]     = !((&hi[r]) || !(|hi[r]));
         // clip to the rail that matches the sign
         clip[r]    = ovf[r] ? {shifted[r][SW-1], {(COORD_WIDTH-1){!shifted[r][SW-1]}}}
                             : shifted[r][COORD_WIDTH-1:0];
      end
      rsp_in.x_out     = DATA_W'(clip[0]);
      rsp_in.y_out     = DATA_W'(clip[1]);
      rsp_in.z_out     = DATA_W'(clip[2]);
      rsp_in.w_out     = DATA_W'(clip[3]);
      rsp_in.saturated = |ovf;
   end

   assign in_ready = !vld_ff || out_ready;
   assign vld_in   = in_ready ? in_valid : vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = vld_ff;
   assign rsp_o     = rsp_ff;

endmodule

`default_nettype wire

// File: src/homogeneous_vertex_transform_unit.sv
// Top level of the homogeneous vertex transform unit: matrix registers and pipeline.
// Depends on hvt_pkg, hvt_mul_array, hvt_sum_tree, hvt_round_sat and the macros header.
//
//   channel   direction  handshake              payload
//   req_      in         req_valid / req_ready  req_data  (req_type: x, y, z, w, w_given)
//   rsp_      out        rsp_valid / rsp_ready  rsp_data  (rsp_type: x, y, z, w, saturated)
//   csr_      in         csr_we (no wait)       csr_index, csr_wdata (64-bit half matrix column)
//
// One req beat enters per cycle while rsp_ready is high; each beat passes every stage in order.
// The four stages are: 16 products, pairwise sums, row sum plus rounding, shift and saturate.
// Each stage holds its own valid bit and advances when the next stage is empty or advancing,
// so a stalled rsp beat backs up the pipe without dropping or repeating data, and bubbles close.
// Synchronous reset clears all valid bits and loads the identity matrix.
`default_nettype none
`include "homogeneous_vertex_transform_unit_macros.svh"

module homogeneous_vertex_transform_unit
   import hvt_pkg::*;
#(
   parameter int FRAC_BITS   = FRAC_BITS_DEFAULT,
   parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   // vertex input
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   // transformed vertex output
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   // matrix register writes
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [REG_W-1:0]     csr_wdata
);

   localparam int OPW = opnd_width(COORD_WIDTH, FRAC_BITS);
   localparam int PW  = MAT_W + OPW;
   localparam int SW  = PW + 3;

   logic [REG_W-1:0]     mat_in [NUM_REGS];
   logic [REG_W-1:0]     mat_ff [NUM_REGS];
   logic signed [PW-1:0] prod   [VEC_N][VEC_N];
   logic signed [SW-1:0] rsum   [VEC_N];
   logic                 mul_valid, mul_ready;
   logic                 sum_valid, sum_ready;

   // Matrix registers: decode the index, drop writes beyond the last register.
   always_comb begin
      mat_in = mat_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_COL1_ROWS12: mat_in[0] = csr_wdata;
            REG_COL1_ROWS34: mat_in[1] = csr_wdata;
            REG_COL2_ROWS12: mat_in[2] = csr_wdata;
            REG_COL2_ROWS34: mat_in[3] = csr_wdata;
            REG_COL3_ROWS12: mat_in[4] = csr_wdata;
            REG_COL3_ROWS34: mat_in[5] = csr_wdata;
            REG_COL4_ROWS12: mat_in[6] = csr_wdata;
            REG_COL4_ROWS34: mat_in[7] = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mat_ff <= REG_RESET;
      end else begin
         mat_ff <= mat_in;
      end
   end

   // Stage 1: products of matrix entries and coordinates.
   hvt_mul_array #(
      .FRAC_BITS   (FRAC_BITS),
      .COORD_WIDTH (COORD_WIDTH)
   ) u_mul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .req_i     (req_data),
      .mat_i     (mat_ff),
      .out_valid (mul_valid),
      .out_ready (mul_ready),
      .prod_o    (prod)
   );

   // Stages 2 and 3: exact row sums with rounding bias.
   hvt_sum_tree #(
      .FRAC_BITS   (FRAC_BITS),
      .COORD_WIDTH (COORD_WIDTH)
   ) u_sum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mul_valid),
      .in_ready  (mul_ready),
      .prod_i    (prod),
      .out_valid (sum_valid),
      .out_ready (sum_ready),
      .sum_o     (rsum)
   );

   // Stage 4: shift, saturate and hold the rsp beat.
   hvt_round_sat #(
      .FRAC_BITS   (FRAC_BITS),
      .COORD_WIDTH (COORD_WIDTH)
   ) u_rnd (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sum_valid),
      .in_ready  (sum_ready),
      .sum_i     (rsum),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .rsp_o     (rsp_data)
   );

   // Reset empties the pipe.
   `HVT_ASSERT_NXT_ALWAYS(a_reset_empties, clock, reset, !rsp_valid)
   // A free-running output never throttles the input.
   `HVT_ASSERT_IMP(a_no_false_stall, clock, reset, rsp_ready, req_ready)
   // With the output taking beats, an accepted beat emerges as a valid rsp beat.
   `HVT_ASSERT_NXT(a_latency, clock, reset, req_valid && req_ready ##1 rsp_ready ##1 rsp_ready ##1 rsp_ready, rsp_valid)

endmodule

`default_nettype wire
